>>> hdl/mua_pkg.sv
// ----------------------------------------------------------------------------
// mua_pkg
// Shared widths, types and arithmetic helpers for the upwind momentum
// coefficient assembly: face rule, product rounding and 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package mua_pkg;

	// Fixed-point format and field widths
	localparam int FRAC_BITS = 16;
	localparam int FLUX_W    = 32;
	localparam int COND_W    = 31;
	localparam int SOLID_W   = 7;
	localparam int EDGE_W    = 6;
	localparam int NUM_FACES = 6;
	localparam int NUM_OUT   = 8;
	localparam int CFG_IDX_W = 3;

	// Internal widths: face terms, exact accumulators, rounded products
	localparam int TERM_W = 34;
	localparam int ACC_W  = 52;
	localparam int PROD_W = 66;

	localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) <<< (FRAC_BITS - 1);
	localparam logic [FLUX_W-1:0] ONE_Q = FLUX_W'(1) << FRAC_BITS;

	// Face slots, in the order of the neighbour coefficients
	localparam int FACE_WEST  = 0;
	localparam int FACE_EAST  = 1;
	localparam int FACE_SOUTH = 2;
	localparam int FACE_NORTH = 3;
	localparam int FACE_BACK  = 4;
	localparam int FACE_FRONT = 5;

	// Flag bit positions
	localparam int SOLID_CENTRE = 0;
	localparam int EDGE_WEST    = 0;
	localparam int EDGE_EAST    = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COND_X         = 3'd0,
		REG_COND_Y         = 3'd1,
		REG_COND_Z         = 3'd2,
		REG_INLET_VELOCITY = 3'd3,
		REG_AREA_X         = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic        [COND_W-1:0] cond_x;
		logic        [COND_W-1:0] cond_y;
		logic        [COND_W-1:0] cond_z;
		logic signed [FLUX_W-1:0] inlet_velocity;
		logic        [COND_W-1:0] area_x;
	} cfg_t;

	typedef struct packed {
		logic adv1;
		logic adv2;
		logic adv3;
		logic adv4;
	} pipe_adv_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] cen;
		logic signed [TERM_W-1:0] nb;
	} face_t;

	typedef struct packed {
		logic signed [FLUX_W-1:0] val;
		logic                     sat;
	} clip_t;

	// One interior or wall face: wall adds 2g to the centre, otherwise
	// diffusion plus first-order upwind convection on the outflow.
	function automatic face_t face_fn(input logic [COND_W-1:0] g, input logic wall,
			input logic signed [FLUX_W:0] outflow);
		face_t r;
		logic signed [TERM_W-1:0] gs;
		logic signed [TERM_W-1:0] of;
		gs = TERM_W'($signed({1'b0, g}));
		of = TERM_W'(outflow);
		if (wall) begin
			r.cen = gs <<< 1;
			r.nb  = '0;
		end else if (outflow[FLUX_W]) begin
			r.cen = gs;
			r.nb  = of - gs;
		end else begin
			r.cen = gs + of;
			r.nb  = -gs;
		end
		return r;
	endfunction

	// Drop the fraction bits, round to nearest with ties toward plus infinity
	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] q;
		q = p + HALF_P;
		q = q >>> FRAC_BITS;
		return q[ACC_W-1:0];
	endfunction

	// Clip an exact sum into the signed 32-bit range
	function automatic clip_t clip32(input logic signed [ACC_W-1:0] v);
		clip_t r;
		if ((&v[ACC_W-1:FLUX_W-1]) || (~|v[ACC_W-1:FLUX_W-1])) begin
			r.val = v[FLUX_W-1:0];
			r.sat = 1'b0;
		end else begin
			r.val = v[ACC_W-1] ? {1'b1, {(FLUX_W-1){1'b0}}} : {1'b0, {(FLUX_W-1){1'b1}}};
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/mua_cfg_regs.sv
// ----------------------------------------------------------------------------
// mua_cfg_regs
// Configuration register file: conductances, inlet velocity and x face area.
// ----------------------------------------------------------------------------
`default_nettype none

module mua_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mua_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mua_pkg::FLUX_W-1:0]      cfg_data,
	output mua_pkg::cfg_t                   cfg
);
	import mua_pkg::*;

	cfg_t cfg_q;

	// Every write beat is taken at once
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Decode the index and store; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_COND_X:         cfg_q.cond_x <= cfg_data[COND_W-1:0];
				REG_COND_Y:         cfg_q.cond_y <= cfg_data[COND_W-1:0];
				REG_COND_Z:         cfg_q.cond_z <= cfg_data[COND_W-1:0];
				REG_INLET_VELOCITY: cfg_q.inlet_velocity <= $signed(cfg_data);
				REG_AREA_X:         cfg_q.area_x <= cfg_data[COND_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/mua_face_terms.sv
// ----------------------------------------------------------------------------
// mua_face_terms
// Per-face centre contribution and neighbour coefficient for one cell,
// with inlet, outlet, wall and solid-neighbour handling.
// ----------------------------------------------------------------------------
`default_nettype none

module mua_face_terms (
	input  mua_pkg::cfg_t                                     cfg,
	input  logic        [mua_pkg::SOLID_W-1:0]                solid_flags,
	input  logic        [mua_pkg::EDGE_W-1:0]                 edge_flags,
	input  logic signed [mua_pkg::FLUX_W-1:0]                 flux_east_out,
	input  logic signed [mua_pkg::FLUX_W-1:0]                 flux_west_in,
	input  logic signed [mua_pkg::FLUX_W-1:0]                 flux_north_out,
	input  logic signed [mua_pkg::FLUX_W-1:0]                 flux_south_in,
	input  logic signed [mua_pkg::FLUX_W-1:0]                 flux_front_out,
	input  logic signed [mua_pkg::FLUX_W-1:0]                 flux_back_in,
	output mua_pkg::face_t [mua_pkg::NUM_FACES-1:0]           faces
);
	import mua_pkg::*;

	logic signed [FLUX_W:0] out_w;
	logic signed [FLUX_W:0] out_e;
	logic signed [FLUX_W:0] out_s;
	logic signed [FLUX_W:0] out_n;
	logic signed [FLUX_W:0] out_b;
	logic signed [FLUX_W:0] out_f;

	// Outflow per face: an incoming neighbour flux is negated
	assign out_w = -$signed({flux_west_in[FLUX_W-1], flux_west_in});
	assign out_e = $signed({flux_east_out[FLUX_W-1], flux_east_out});
	assign out_s = -$signed({flux_south_in[FLUX_W-1], flux_south_in});
	assign out_n = $signed({flux_north_out[FLUX_W-1], flux_north_out});
	assign out_b = -$signed({flux_back_in[FLUX_W-1], flux_back_in});
	assign out_f = $signed({flux_front_out[FLUX_W-1], flux_front_out});

	always_comb begin
		// Inlet adds 2g to the centre just like a wall
		faces[FACE_WEST] = face_fn(cfg.cond_x,
			edge_flags[EDGE_WEST] | solid_flags[FACE_WEST+1], out_w);

		// Outlet keeps only positive outflow on the centre
		if (edge_flags[EDGE_EAST]) begin
			faces[FACE_EAST].cen = out_e[FLUX_W] ? '0 : TERM_W'(out_e);
			faces[FACE_EAST].nb  = '0;
		end else begin
			faces[FACE_EAST] = face_fn(cfg.cond_x, solid_flags[FACE_EAST+1], out_e);
		end

		faces[FACE_SOUTH] = face_fn(cfg.cond_y,
			edge_flags[FACE_SOUTH] | solid_flags[FACE_SOUTH+1], out_s);
		faces[FACE_NORTH] = face_fn(cfg.cond_y,
			edge_flags[FACE_NORTH] | solid_flags[FACE_NORTH+1], out_n);
		faces[FACE_BACK]  = face_fn(cfg.cond_z,
			edge_flags[FACE_BACK] | solid_flags[FACE_BACK+1], out_b);
		faces[FACE_FRONT] = face_fn(cfg.cond_z,
			edge_flags[FACE_FRONT] | solid_flags[FACE_FRONT+1], out_f);
	end

endmodule

`default_nettype wire

>>> hdl/mua_src_path.sv
// ----------------------------------------------------------------------------
// mua_src_path
// Source term pipeline: inlet conduction and momentum products, outlet
// backflow product, rounding and the clipped inlet flow rate.
// ----------------------------------------------------------------------------
`default_nettype none

module mua_src_path (
	input  logic                                   clk,
	input  mua_pkg::cfg_t                          cfg,
	input  mua_pkg::pipe_adv_t                     adv,
	input  logic signed [mua_pkg::FLUX_W-1:0]      flux_east_out,
	input  logic                                   inlet_west,
	input  logic                                   outlet_back,
	output logic signed [2*mua_pkg::FLUX_W-1:0]    prod_v_s3,
	output logic signed [mua_pkg::ACC_W-1:0]       part_s3,
	output logic                                   sat_v_s3
);
	import mua_pkg::*;

	logic signed [FLUX_W:0]       neg_fe;
	logic signed [FLUX_W-1:0]     area_s;
	logic signed [FLUX_W-1:0]     gx_s;
	logic signed [2*FLUX_W-1:0]   prod_a_s1;
	logic signed [2*FLUX_W-1:0]   prod_g_s1;
	logic signed [2*FLUX_W:0]     prod_o_s1;
	logic                         west_s1;
	logic                         oback_s1;
	clip_t                        vel_clip;
	logic signed [ACC_W-1:0]      rnd_g;
	logic signed [ACC_W-1:0]      rnd_o;
	logic signed [FLUX_W-1:0]     vq_s2;
	logic                         sat_v_s2;
	logic signed [ACC_W-1:0]      rg_s2;
	logic signed [ACC_W-1:0]      ro_s2;

	assign neg_fe = -$signed({flux_east_out[FLUX_W-1], flux_east_out});
	assign area_s = $signed({1'b0, cfg.area_x});
	assign gx_s   = $signed({1'b0, cfg.cond_x});

	// Stage 1: the three independent products
	always_ff @(posedge clk) begin
		if (adv.adv1) begin
			prod_a_s1 <= area_s * cfg.inlet_velocity;
			prod_g_s1 <= gx_s * cfg.inlet_velocity;
			prod_o_s1 <= neg_fe * cfg.inlet_velocity;
			west_s1   <= inlet_west;
			oback_s1  <= outlet_back;
		end
	end

	// Stage 2: round, clip the inlet flow rate, gate by boundary kind
	always_comb begin
		vel_clip = clip32(rnd(PROD_W'(prod_a_s1)));
		rnd_g    = rnd(PROD_W'(prod_g_s1) <<< 1);
		rnd_o    = rnd(PROD_W'(prod_o_s1));
	end

	always_ff @(posedge clk) begin
		if (adv.adv2) begin
			vq_s2    <= west_s1 ? vel_clip.val : '0;
			sat_v_s2 <= west_s1 & vel_clip.sat;
			rg_s2    <= west_s1 ? rnd_g : '0;
			ro_s2    <= oback_s1 ? rnd_o : '0;
		end
	end

	// Stage 3: inlet momentum product and partial source sum
	always_ff @(posedge clk) begin
		if (adv.adv3) begin
			prod_v_s3 <= vq_s2 * cfg.inlet_velocity;
			part_s3   <= rg_s2 + ro_s2;
			sat_v_s3  <= sat_v_s2;
		end
	end

endmodule

`default_nettype wire

>>> hdl/momentum_upwind_coeff_assembly.sv
// ----------------------------------------------------------------------------
// momentum_upwind_coeff_assembly
// Seven-point upwind momentum coefficients and x source for one grid cell.
// ----------------------------------------------------------------------------
// The block takes one cell per cycle when not stalled; its result beat leaves
// the last of four register stages, set by the two dependent multiplications
// of the inlet source (flow rate, then momentum) with a register after each.
// A stalled output holds its beat and backs pressure up through the stages,
// so bubbles close up and throughput stays at one cell per cycle while the
// downstream side takes beats. Configuration writes complete in the cycle
// they are offered and must only be made while no cell is in flight.
`default_nettype none

module momentum_upwind_coeff_assembly (
	input  logic                                          clk,
	input  logic                                          arst_n,
	// configuration write channel
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [mua_pkg::CFG_IDX_W-1:0]                 cfg_index,
	input  logic [mua_pkg::FLUX_W-1:0]                    cfg_data,
	// cell stream
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// flux_east_out, flux_west_in, flux_north_out, flux_south_in,
	// flux_front_out, flux_back_in
	input  logic [mua_pkg::NUM_FACES*mua_pkg::FLUX_W-1:0] s_axis_tdata,
	// solid_flags, edge_flags
	input  logic [mua_pkg::SOLID_W+mua_pkg::EDGE_W-1:0]   s_axis_tuser,
	// coefficient stream
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// coeff_centre, coeff_west, coeff_east, coeff_south, coeff_north,
	// coeff_back, coeff_front, source_x
	output logic [mua_pkg::NUM_OUT*mua_pkg::FLUX_W-1:0]   m_axis_tdata,
	// saturated
	output logic                                          m_axis_tuser
);
	import mua_pkg::*;

	cfg_t                        cfg;
	pipe_adv_t                   adv;
	logic [SOLID_W-1:0]          solid_flags;
	logic [EDGE_W-1:0]           edge_flags;
	logic signed [FLUX_W-1:0]    flux_east_out;
	face_t [NUM_FACES-1:0]       faces;

	logic                        vld_s1_q;
	logic                        vld_s2_q;
	logic                        vld_s3_q;
	logic                        vld_s4_q;

	face_t [NUM_FACES-1:0]       faces_s1;
	logic                        solid_s1;
	logic signed [ACC_W-1:0]     cen_a_s2 [NUM_FACES/2];
	logic signed [TERM_W-1:0]    nb_s2 [NUM_FACES];
	logic                        solid_s2;
	logic signed [ACC_W-1:0]     cen_s3;
	logic signed [TERM_W-1:0]    nb_s3 [NUM_FACES];
	logic                        solid_s3;
	logic signed [2*FLUX_W-1:0]  prod_v_s3;
	logic signed [ACC_W-1:0]     part_s3;
	logic                        sat_v_s3;
	logic [NUM_OUT*FLUX_W-1:0]   data_s4;
	logic                        sat_s4;

	clip_t                       clips [NUM_OUT];
	logic [NUM_OUT*FLUX_W-1:0]   data_nxt;
	logic                        sat_nxt;

	// Unpack the input beat
	assign solid_flags   = s_axis_tuser[SOLID_W-1:0];
	assign edge_flags    = s_axis_tuser[SOLID_W +: EDGE_W];
	assign flux_east_out = $signed(s_axis_tdata[0*FLUX_W +: FLUX_W]);

	mua_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mua_face_terms u_faces (
		.cfg            (cfg),
		.solid_flags    (solid_flags),
		.edge_flags     (edge_flags),
		.flux_east_out  (flux_east_out),
		.flux_west_in   ($signed(s_axis_tdata[1*FLUX_W +: FLUX_W])),
		.flux_north_out ($signed(s_axis_tdata[2*FLUX_W +: FLUX_W])),
		.flux_south_in  ($signed(s_axis_tdata[3*FLUX_W +: FLUX_W])),
		.flux_front_out ($signed(s_axis_tdata[4*FLUX_W +: FLUX_W])),
		.flux_back_in   ($signed(s_axis_tdata[5*FLUX_W +: FLUX_W])),
		.faces          (faces)
	);

	mua_src_path u_src (
		.clk           (clk),
		.cfg           (cfg),
		.adv           (adv),
		.flux_east_out (flux_east_out),
		.inlet_west    (edge_flags[EDGE_WEST]),
		.outlet_back   (edge_flags[EDGE_EAST] & flux_east_out[FLUX_W-1]),
		.prod_v_s3     (prod_v_s3),
		.part_s3       (part_s3),
		.sat_v_s3      (sat_v_s3)
	);

	// Advance a stage when it is empty or the stage after it advances
	always_comb begin
		adv.adv4 = ~vld_s4_q | m_axis_tready;
		adv.adv3 = ~vld_s3_q | adv.adv4;
		adv.adv2 = ~vld_s2_q | adv.adv3;
		adv.adv1 = ~vld_s1_q | adv.adv2;
	end

	assign s_axis_tready = adv.adv1;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q <= 1'b0;
			vld_s2_q <= 1'b0;
			vld_s3_q <= 1'b0;
			vld_s4_q <= 1'b0;
		end else begin
			if (adv.adv1) vld_s1_q <= s_axis_tvalid;
			if (adv.adv2) vld_s2_q <= vld_s1_q;
			if (adv.adv3) vld_s3_q <= vld_s2_q;
			if (adv.adv4) vld_s4_q <= vld_s3_q;
		end
	end

	// Stage 1: register face terms
	always_ff @(posedge clk) begin
		if (adv.adv1) begin
			faces_s1 <= faces;
			solid_s1 <= solid_flags[SOLID_CENTRE];
		end
	end

	// Stage 2: pairwise centre sums
	always_ff @(posedge clk) begin
		if (adv.adv2) begin
			for (int k = 0; k < NUM_FACES/2; k++) begin
				cen_a_s2[k] <= ACC_W'(faces_s1[2*k].cen) + ACC_W'(faces_s1[2*k+1].cen);
			end
			for (int k = 0; k < NUM_FACES; k++) begin
				nb_s2[k] <= faces_s1[k].nb;
			end
			solid_s2 <= solid_s1;
		end
	end

	// Stage 3: full centre sum
	always_ff @(posedge clk) begin
		if (adv.adv3) begin
			cen_s3   <= cen_a_s2[0] + cen_a_s2[1] + cen_a_s2[2];
			nb_s3    <= nb_s2;
			solid_s3 <= solid_s2;
		end
	end

	// Stage 4: finish the source, clip every field, apply the solid override
	always_comb begin
		clips[0] = clip32(cen_s3);
		for (int k = 0; k < NUM_FACES; k++) begin
			clips[k+1] = clip32(ACC_W'(nb_s3[k]));
		end
		clips[NUM_OUT-1] = clip32(part_s3 + rnd(PROD_W'(prod_v_s3)));

		sat_nxt = sat_v_s3;
		for (int k = 0; k < NUM_OUT; k++) begin
			data_nxt[k*FLUX_W +: FLUX_W] = clips[k].val;
			sat_nxt = sat_nxt | clips[k].sat;
		end

		if (solid_s3) begin
			data_nxt = '0;
			data_nxt[0 +: FLUX_W] = ONE_Q;
			sat_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.adv4) begin
			data_s4 <= data_nxt;
			sat_s4  <= sat_nxt;
		end
	end

	assign m_axis_tvalid = vld_s4_q;
	assign m_axis_tdata  = data_s4;
	assign m_axis_tuser  = sat_s4;

endmodule

`default_nettype wire

>>> hdl/mua_checker.sv
// ----------------------------------------------------------------------------
// mua_checker
// Port-level checks on the coefficient assembly, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mua_checker (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	input  logic                                          s_axis_tready,
	input  logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	input  logic [mua_pkg::NUM_OUT*mua_pkg::FLUX_W-1:0]   m_axis_tdata,
	input  logic                                          m_axis_tuser
);
	import mua_pkg::*;

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result beat changed");

	// A free output side never stalls the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// Centre coefficient is a sum of non-negative terms
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[FLUX_W-1])
		else $error("negative centre coefficient");

	// Neighbour coefficients are never positive
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[2*FLUX_W-1] || m_axis_tdata[1*FLUX_W +: FLUX_W] == '0) &&
			(m_axis_tdata[3*FLUX_W-1] || m_axis_tdata[2*FLUX_W +: FLUX_W] == '0) &&
			(m_axis_tdata[4*FLUX_W-1] || m_axis_tdata[3*FLUX_W +: FLUX_W] == '0) &&
			(m_axis_tdata[5*FLUX_W-1] || m_axis_tdata[4*FLUX_W +: FLUX_W] == '0) &&
			(m_axis_tdata[6*FLUX_W-1] || m_axis_tdata[5*FLUX_W +: FLUX_W] == '0) &&
			(m_axis_tdata[7*FLUX_W-1] || m_axis_tdata[6*FLUX_W +: FLUX_W] == '0))
		else $error("positive neighbour coefficient");

endmodule

bind momentum_upwind_coeff_assembly mua_checker u_mua_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
